@@ src/rcm_pkg.sv @@
`default_nettype none
package rcm_pkg;

   localparam int CHANNELS  = 3;
   localparam int CH_BITS   = 2;
   localparam int SUM_BITS  = 29;
   localparam int WIN_BITS  = 11;
   localparam int GAIN_BITS = 16;
   localparam int OUT_BITS  = 16;
   localparam int FRAC_BITS = 16;
   localparam int CSR_BITS  = 16;
   localparam int CSR_IDX_BITS = 2;

   // quotient register carries one leading zero so the root takes digit pairs
   localparam int DIV_BITS  = SUM_BITS + FRAC_BITS + 1;
   localparam int ROOT_BITS = DIV_BITS / 2;
   localparam int PROD_BITS = ROOT_BITS + GAIN_BITS;

   localparam logic [WIN_BITS-1:0]  MAX_WINDOW   = 11'd1024;
   localparam logic [WIN_BITS-1:0]  WINDOW_RESET = 11'd250;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET   = 16'd18939;
   localparam int                   OFFSET_RESET = 510;
   localparam logic [SUM_BITS-1:0]  SUM_MAX      = {SUM_BITS{1'b1}};
   localparam logic [OUT_BITS-1:0]  OUT_MAX      = {OUT_BITS{1'b1}};

   localparam logic [CSR_IDX_BITS-1:0] CSR_ZERO_OFFSET   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_LENGTH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAIN          = 2'd2;

   typedef struct packed {
      logic                 start;
      logic [SUM_BITS-1:0]  sum;
      logic [WIN_BITS-1:0]  window;
      logic [GAIN_BITS-1:0] gain;
   } rcm_root_req_type;

   typedef struct packed {
      logic                done;
      logic [OUT_BITS-1:0] ma;
   } rcm_root_rsp_type;

endpackage
`default_nettype wire

@@ src/rcm_root_unit.sv @@
`default_nettype none
module rcm_root_unit
   import rcm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rcm_root_req_type cmd,
   output rcm_root_rsp_type      res
);

   typedef enum logic [4:0] {
      U_IDLE = 5'b00001,
      U_DIV  = 5'b00010,
      U_SQRT = 5'b00100,
      U_MUL  = 5'b01000,
      U_FIN  = 5'b10000
   } unit_state_type;

   localparam int STEP_BITS = $clog2(DIV_BITS);
   localparam int SQ_REM_BITS = ROOT_BITS + 3;

   unit_state_type state_ff, state_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [DIV_BITS-1:0]    div_ff, div_in;
   logic [WIN_BITS-1:0]    rem_ff, rem_in;
   logic [WIN_BITS-1:0]    window_ff, window_in;
   logic [GAIN_BITS-1:0]   gain_ff, gain_in;
   logic [SQ_REM_BITS-1:0] sq_rem_ff, sq_rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;

   logic [WIN_BITS:0]      div_trial;
   logic                   div_ge;
   logic [SQ_REM_BITS-1:0] sq_trial;
   logic [SQ_REM_BITS-1:0] sq_cand;
   logic                   sq_ge;
   logic [ROOT_BITS:0]     mul_sum;
   logic [ROOT_BITS:0]     rounded;

   // restoring divide, one quotient bit a cycle
   assign div_trial = {rem_ff, div_ff[DIV_BITS-1]};
   assign div_ge    = div_trial >= {1'b0, window_ff};

   // root digit by digit, two radicand bits a cycle
   assign sq_trial = {sq_rem_ff[SQ_REM_BITS-3:0], div_ff[DIV_BITS-1 -: 2]};
   assign sq_cand  = SQ_REM_BITS'({root_ff, 2'b01});
   assign sq_ge    = sq_trial >= sq_cand;

   // shift-add multiply, one gain bit a cycle
   assign mul_sum = {1'b0, prod_ff[PROD_BITS-1:GAIN_BITS]}
                  + (prod_ff[0] ? {1'b0, root_ff} : {(ROOT_BITS+1){1'b0}});

   assign rounded = {1'b0, prod_ff[PROD_BITS-1:FRAC_BITS]}
                  + {{ROOT_BITS{1'b0}}, prod_ff[FRAC_BITS-1]};

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      window_in = window_ff;
      gain_in   = gain_ff;
      sq_rem_in = sq_rem_ff;
      root_in   = root_ff;
      prod_in   = prod_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               div_in    = {1'b0, cmd.sum, {FRAC_BITS{1'b0}}};
               rem_in    = '0;
               window_in = cmd.window;
               gain_in   = cmd.gain;
               step_in   = STEP_BITS'(DIV_BITS - 1);
               state_in  = U_DIV;
            end
         end
         U_DIV: begin
            rem_in = div_ge ? WIN_BITS'(div_trial - {1'b0, window_ff})
                            : div_trial[WIN_BITS-1:0];
            div_in = {div_ff[DIV_BITS-2:0], div_ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               sq_rem_in = '0;
               root_in   = '0;
               step_in   = STEP_BITS'(ROOT_BITS - 1);
               state_in  = U_SQRT;
            end
         end
         U_SQRT: begin
            sq_rem_in = sq_ge ? (sq_trial - sq_cand) : sq_trial;
            root_in   = {root_ff[ROOT_BITS-2:0], sq_ge};
            div_in    = {div_ff[DIV_BITS-3:0], 2'b00};
            step_in   = step_ff - 1'b1;
            if (step_ff == '0) begin
               prod_in  = {{ROOT_BITS{1'b0}}, gain_ff};
               step_in  = STEP_BITS'(GAIN_BITS - 1);
               state_in = U_MUL;
            end
         end
         U_MUL: begin
            prod_in = {mul_sum, prod_ff[GAIN_BITS-1:1]};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = U_FIN;
            end
         end
         U_FIN: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_comb begin
      res.done = state_ff == U_FIN;
      res.ma   = (rounded > (ROOT_BITS+1)'(OUT_MAX)) ? OUT_MAX : rounded[OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff   <= step_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      window_ff <= window_in;
      gain_ff   <= gain_in;
      sq_rem_ff <= sq_rem_in;
      root_ff   <= root_in;
      prod_ff   <= prod_in;
   end

endmodule
`default_nettype wire

@@ src/rms_current_meter_3ch.sv @@
`default_nettype none
// channel    ports                                           role
// request    req_valid req_stall req_sample_a/b/c            three raw samples in
// response   rsp_valid rsp_stall rsp_rms_a_ma/b_ma/c_ma      rms per channel, mA
// csr        csr_write csr_index csr_wdata                   offset, window, gain
//
// the squares of a request are built two bits a cycle in three parallel lanes.
// the request that closes a window then runs each channel in turn through one shared
// unit: start, divide, root, gain multiply, finish.
// reset is synchronous, restores the register defaults and clears the sums.
// a stalled response holds while requests go on; only the next window result waits.
module rms_current_meter_3ch
   import rcm_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [SAMPLE_BITS-1:0]  req_sample_a,
   input  wire logic [SAMPLE_BITS-1:0]  req_sample_b,
   input  wire logic [SAMPLE_BITS-1:0]  req_sample_c,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [OUT_BITS-1:0]          rsp_rms_a_ma,
   output logic [OUT_BITS-1:0]          rsp_rms_b_ma,
   output logic [OUT_BITS-1:0]          rsp_rms_c_ma,
   input  wire logic                    csr_write,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [CSR_BITS-1:0]     csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SQUARE = 4'b0010,
      ST_ROOT   = 4'b0100,
      ST_PUSH   = 4'b1000
   } state_type;

   localparam int DIGITS   = (SAMPLE_BITS + 1) / 2;
   localparam int DIG_BITS = $clog2(DIGITS + 1);
   localparam int SQ_BITS  = 2 * SAMPLE_BITS;
   localparam int PART_BITS = SQ_BITS + 2;
   localparam int ADD_BITS = ((SUM_BITS > PART_BITS) ? SUM_BITS : PART_BITS) + 1;
   localparam logic [ADD_BITS-1:0] SUM_LIMIT = ADD_BITS'(SUM_MAX);

   state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] offset_ff, offset_in;
   logic [WIN_BITS-1:0]    window_ff, window_in;
   logic [GAIN_BITS-1:0]   gain_ff, gain_in;

   logic [SUM_BITS-1:0]    sums_ff [CHANNELS];
   logic [SUM_BITS-1:0]    sums_in [CHANNELS];
   logic [SQ_BITS-1:0]     mcand_ff [CHANNELS];
   logic [SQ_BITS-1:0]     mcand_in [CHANNELS];
   logic [SAMPLE_BITS-1:0] mplier_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] mplier_in [CHANNELS];
   logic [WIN_BITS-1:0]    taken_ff, taken_in;
   logic [DIG_BITS-1:0]    digit_ff, digit_in;
   logic [CH_BITS-1:0]     ch_ff, ch_in;
   logic                   start_ff, start_in;
   logic [OUT_BITS-1:0]    res_ff [CHANNELS];
   logic [OUT_BITS-1:0]    res_in [CHANNELS];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]    rsp_ma_ff [CHANNELS];
   logic [OUT_BITS-1:0]    rsp_ma_in [CHANNELS];

   logic [SAMPLE_BITS-1:0] sample [CHANNELS];
   logic [SAMPLE_BITS-1:0] mag [CHANNELS];
   logic [PART_BITS-1:0]   part [CHANNELS];
   logic [ADD_BITS-1:0]    acc [CHANNELS];
   logic [WIN_BITS-1:0]    eff_window;
   logic                   req_take;
   logic                   out_free;

   rcm_root_req_type root_req;
   rcm_root_rsp_type root_rsp;

   assign sample[0] = req_sample_a;
   assign sample[1] = req_sample_b;
   assign sample[2] = req_sample_c;

   assign req_stall = state_ff != ST_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      priority if (window_ff == '0) begin
         eff_window = WIN_BITS'(1);
      end else if (window_ff > MAX_WINDOW) begin
         eff_window = MAX_WINDOW;
      end else begin
         eff_window = window_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         mag[i] = (sample[i] >= offset_ff) ? (sample[i] - offset_ff)
                                           : (offset_ff - sample[i]);
         part[i] = (mplier_ff[i][0] ? PART_BITS'(mcand_ff[i]) : '0)
                 + (mplier_ff[i][1] ? PART_BITS'({mcand_ff[i], 1'b0}) : '0);
         acc[i]  = ADD_BITS'(sums_ff[i]) + ADD_BITS'(part[i]);
      end
   end

   // configuration
   always_comb begin
      offset_in = offset_ff;
      window_in = window_ff;
      gain_in   = gain_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ZERO_OFFSET:   offset_in = csr_wdata[SAMPLE_BITS-1:0];
            CSR_WINDOW_LENGTH: window_in = csr_wdata[WIN_BITS-1:0];
            CSR_GAIN:          gain_in   = csr_wdata[GAIN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      sums_in      = sums_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      taken_in     = taken_ff;
      digit_in     = digit_ff;
      ch_in        = ch_ff;
      start_in     = 1'b0;
      res_in       = res_ff;
      rsp_ma_in    = rsp_ma_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               for (int i = 0; i < CHANNELS; i++) begin
                  mcand_in[i]  = SQ_BITS'(mag[i]);
                  mplier_in[i] = mag[i];
               end
               taken_in = taken_ff + 1'b1;
               digit_in = DIG_BITS'(DIGITS - 1);
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            // saturating each partial sum gives the same as saturating the total
            for (int i = 0; i < CHANNELS; i++) begin
               sums_in[i]   = (acc[i] > SUM_LIMIT) ? SUM_MAX : acc[i][SUM_BITS-1:0];
               mcand_in[i]  = {mcand_ff[i][SQ_BITS-3:0], 2'b00};
               mplier_in[i] = mplier_ff[i] >> 2;
            end
            digit_in = digit_ff - 1'b1;
            if (digit_ff == '0) begin
               if (taken_ff >= eff_window) begin
                  taken_in = '0;
                  ch_in    = '0;
                  start_in = 1'b1;
                  state_in = ST_ROOT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ROOT: begin
            // the unit latches the sum at start, so it can clear right away
            if (start_ff) begin
               sums_in[ch_ff] = '0;
            end
            if (root_rsp.done) begin
               res_in[ch_ff] = root_rsp.ma;
               if (ch_ff == CH_BITS'(CHANNELS - 1)) begin
                  state_in = ST_PUSH;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  start_in = 1'b1;
               end
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               rsp_ma_in    = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      root_req.start  = start_ff;
      root_req.sum    = sums_ff[ch_ff];
      root_req.window = eff_window;
      root_req.gain   = gain_ff;
   end

   rcm_root_unit u_root (
      .clock (clock),
      .reset (reset),
      .cmd   (root_req),
      .res   (root_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         offset_ff    <= SAMPLE_BITS'(OFFSET_RESET);
         window_ff    <= WINDOW_RESET;
         gain_ff      <= GAIN_RESET;
         taken_ff     <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         window_ff    <= window_in;
         gain_ff      <= gain_in;
         taken_ff     <= taken_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         sums_ff      <= sums_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      digit_ff  <= digit_in;
      ch_ff     <= ch_in;
      res_ff    <= res_in;
      rsp_ma_ff <= rsp_ma_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rms_a_ma = rsp_ma_ff[0];
   assign rsp_rms_b_ma = rsp_ma_ff[1];
   assign rsp_rms_c_ma = rsp_ma_ff[2];

   a_done_in_root: assert property (@(posedge clock) disable iff (reset)
      root_rsp.done |-> state_ff == ST_ROOT)
      else $error("root unit finished outside the window close");

   a_taken_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROOT |-> taken_ff == '0)
      else $error("sample count not cleared while closing a window");

   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PUSH))
      else $error("response raised without a finished window");

   a_taken_bound: assert property (@(posedge clock) disable iff (reset)
      taken_ff <= MAX_WINDOW)
      else $error("sample count ran past the longest window");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import rcm_pkg::*;

   localparam int SMP_W = 10;
   localparam int SETTLE_CYCLES = 300;
   localparam int HOLD_OFF_CYCLES = 1000;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef logic [SMP_W-1:0] sample_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] a_ma;
      logic [OUT_BITS-1:0] b_ma;
      logic [OUT_BITS-1:0] c_ma;
   } rms_triple_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   sample_type              req_sample_a = '0;
   sample_type              req_sample_b = '0;
   sample_type              req_sample_c = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [OUT_BITS-1:0]     rsp_rms_a_ma;
   logic [OUT_BITS-1:0]     rsp_rms_b_ma;
   logic [OUT_BITS-1:0]     rsp_rms_c_ma;
   logic                    csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_BITS-1:0]     csr_wdata = '0;

   // shadow of the meter: register copies and per-channel square sums
   sample_type           zero_code;
   logic [WIN_BITS-1:0]  window_setting;
   logic [GAIN_BITS-1:0] gain_q8;
   logic [SUM_BITS-1:0]  square_acc [3];
   logic [WIN_BITS-1:0]  triples_in_window;
   rms_triple_type       rms_expected [$];

   int error_count = 0;
   int burst_left = 0;
   int hold_off_calls = 0;

   rms_current_meter_3ch #(
      .SAMPLE_BITS(SMP_W)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample_a (req_sample_a),
      .req_sample_b (req_sample_b),
      .req_sample_c (req_sample_c),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_rms_a_ma (rsp_rms_a_ma),
      .rsp_rms_b_ma (rsp_rms_b_ma),
      .rsp_rms_c_ma (rsp_rms_c_ma),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #36_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root, trial;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= v)
            root = trial;
      end
      return root;
   endfunction

   function automatic logic [OUT_BITS-1:0] to_milliamps(logic [SUM_BITS-1:0] sum,
                                                        logic [WIN_BITS-1:0] n);
      longint unsigned mean_q16, ma;
      mean_q16 = sum;
      mean_q16 = (mean_q16 << FRAC_BITS) / n;
      // root of a 16-fraction-bit mean has 8 fraction bits, gain has 8 more
      ma = (floor_sqrt(mean_q16) * gain_q8 + 64'd32768) >> 16;
      return (ma > OUT_MAX) ? OUT_MAX : ma[OUT_BITS-1:0];
   endfunction

   function automatic void predict_request(sample_type sa, sample_type sb, sample_type sc);
      sample_type          smp [3];
      logic [29:0]         mag, total;
      logic [WIN_BITS-1:0] eff;
      rms_triple_type      r;
      smp[0] = sa;
      smp[1] = sb;
      smp[2] = sc;
      for (int ch = 0; ch < 3; ch++) begin
         mag = (smp[ch] >= zero_code) ? smp[ch] - zero_code : zero_code - smp[ch];
         total = square_acc[ch] + mag * mag;
         square_acc[ch] = (total > SUM_MAX) ? SUM_MAX : total[SUM_BITS-1:0];
      end
      triples_in_window = triples_in_window + 1'b1;
      if (window_setting == '0)
         eff = WIN_BITS'(1);
      else if (window_setting > MAX_WINDOW)
         eff = MAX_WINDOW;
      else
         eff = window_setting;
      if (triples_in_window >= eff) begin
         r.a_ma = to_milliamps(square_acc[0], eff);
         r.b_ma = to_milliamps(square_acc[1], eff);
         r.c_ma = to_milliamps(square_acc[2], eff);
         rms_expected.push_back(r);
         for (int ch = 0; ch < 3; ch++)
            square_acc[ch] = '0;
         triples_in_window = '0;
      end
   endfunction

   function automatic sample_type pick_sample(sample_type offset);
      int v;
      if ($urandom_range(2) == 0) begin
         v = $urandom_range(0, 32);
         v = v + offset - 16;
         if (v < 0)
            v = 0;
         if (v > 1023)
            v = 1023;
         return sample_type'(v);
      end
      return sample_type'($urandom);
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   task automatic send_request(sample_type sa, sample_type sb, sample_type sc);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_sample_a <= sa;
      req_sample_b <= sb;
      req_sample_c <= sc;
      do @(posedge clock); while (req_stall);
      predict_request(sa, sb, sc);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rms_expected.size() != 0) @(posedge clock);
      // a request that closes no window may still be in the squaring lanes
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_ZERO_OFFSET:   zero_code = value[SMP_W-1:0];
         CSR_WINDOW_LENGTH: window_setting = value[WIN_BITS-1:0];
         CSR_GAIN:          gain_q8 = value[GAIN_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(sample_type offset, logic [WIN_BITS-1:0] window,
                            logic [GAIN_BITS-1:0] g);
      logic [CSR_BITS-1:0] noise;
      noise = $urandom;
      wait_idle();
      // unused upper bits get random values, the meter must drop them
      write_reg(CSR_ZERO_OFFSET, {noise[CSR_BITS-1:SMP_W], offset});
      write_reg(CSR_WINDOW_LENGTH, {noise[CSR_BITS-1:WIN_BITS], window});
      write_reg(CSR_GAIN, g);
   endtask

   task automatic test_reset_defaults();
      send_request(10'd510, 10'd0, 10'd1023);
      send_request(10'd700, 10'd300, 10'd511);
      send_request(10'd512, 10'd1000, 10'd20);
      wait_idle();
      // three triples already counted, so a window of one closes at once
      write_reg(CSR_WINDOW_LENGTH, 16'd1);
      send_request(10'd600, 10'd400, 10'd100);
   endtask

   task automatic test_field_extremes();
      configure(10'd0, 11'd1, 16'hFFFF);
      send_request(10'd0, 10'd1023, 10'd341);
      send_request(10'd1023, 10'd0, 10'd682);
      send_request(10'd682, 10'd341, 10'd1023);
      configure(10'd1023, 11'd1, 16'd256);
      send_request(10'd0, 10'd1023, 10'd512);
      send_request(10'd1023, 10'd0, 10'd1022);
      wait_idle();
      write_reg(CSR_SPARE, 16'hFFFF);
      send_request(10'd511, 10'd512, 10'd0);
   endtask

   task automatic test_zero_window_and_gain();
      configure(10'd510, 11'd0, 16'd0);
      send_request(10'd0, 10'd1023, 10'd510);
      send_request(10'd1023, 10'd0, 10'd200);
      configure(10'd300, 11'd0, 16'd1);
      send_request(10'd1023, 10'd0, 10'd300);
   endtask

   task automatic test_long_then_short_window();
      // 2047 is clamped to the longest window, nothing comes out yet
      configure(10'd512, 11'd2047, GAIN_RESET);
      send_request(10'd100, 10'd900, 10'd512);
      send_request(10'd0, 10'd1023, 10'd513);
      send_request(10'd300, 10'd700, 10'd511);
      wait_idle();
      write_reg(CSR_WINDOW_LENGTH, 16'd2);
      send_request(10'd1023, 10'd0, 10'd768);
      configure(10'd480, 11'd5, 16'd40000);
      repeat (5) send_request(sample_type'($urandom), sample_type'($urandom),
                              sample_type'($urandom));
   endtask

   task automatic test_random_windows(int target);
      int         sent, win, eff, n;
      sample_type offset;
      logic [GAIN_BITS-1:0] g;
      sent = 0;
      while (sent < target) begin
         case ($urandom_range(5))
            0:       offset = 10'd0;
            1:       offset = 10'd1023;
            default: offset = sample_type'($urandom_range(400, 620));
         endcase
         case ($urandom_range(9))
            0:       win = 0;
            1:       win = $urandom_range(13, 64);
            default: win = $urandom_range(1, 12);
         endcase
         case ($urandom_range(7))
            0:       g = 16'd0;
            1:       g = 16'hFFFF;
            2:       g = GAIN_BITS'($urandom_range(1, 255));
            default: g = GAIN_BITS'($urandom);
         endcase
         configure(offset, WIN_BITS'(win), g);
         eff = (win == 0) ? 1 : win;
         // partial windows carry over into the next setting on purpose
         n = eff * $urandom_range(1, 3) + $urandom_range(0, eff - 1);
         repeat (n) send_request(pick_sample(offset), pick_sample(offset), pick_sample(offset));
         sent += n;
      end
   endtask

   task automatic test_backpressure();
      configure(sample_type'($urandom), 11'd1, GAIN_BITS'($urandom));
      hold_off_calls++;
      repeat (40) send_request(sample_type'($urandom), sample_type'($urandom),
                               sample_type'($urandom));
   endtask

   task automatic test_long_window_saturation();
      sample_type offset;
      logic       high_end;
      high_end = $urandom_range(1);
      offset = high_end ? 10'd0 : 10'd1023;
      configure(offset, WIN_BITS'($urandom_range(1025, 2047)), GAIN_BITS'($urandom));
      // samples pinned to the far rail push the a and b square sums into saturation
      repeat (1024) begin
         if (high_end)
            send_request(sample_type'(1023 - $urandom_range(0, 20)),
                         sample_type'(1023 - $urandom_range(0, 20)), sample_type'($urandom));
         else
            send_request(sample_type'($urandom_range(0, 20)),
                         sample_type'($urandom_range(0, 20)), sample_type'($urandom));
      end
   endtask

   always @(posedge clock) begin : check_rsp
      rms_triple_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rms_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected response %0d %0d %0d",
                                      rsp_rms_a_ma, rsp_rms_b_ma, rsp_rms_c_ma));
         end else begin
            want = rms_expected.pop_front();
            if (rsp_rms_a_ma !== want.a_ma || rsp_rms_b_ma !== want.b_ma ||
                rsp_rms_c_ma !== want.c_ma)
               report_mismatch($sformatf("got %0d %0d %0d, want %0d %0d %0d",
                                         rsp_rms_a_ma, rsp_rms_b_ma, rsp_rms_c_ma,
                                         want.a_ma, want.b_ma, want.c_ma));
         end
      end
   end

   initial begin : rsp_stall_pattern
      int stretch_left;
      int stall_pct;
      int hold_off_left;
      int hold_off_seen;
      stretch_left = 0;
      stall_pct = 0;
      hold_off_left = 0;
      hold_off_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_off_seen != hold_off_calls) begin
            hold_off_seen = hold_off_calls;
            hold_off_left = HOLD_OFF_CYCLES;
         end
         if (hold_off_left > 0) begin
            rsp_stall <= 1'b1;
            hold_off_left--;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(8, 120);
               case ($urandom_range(3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 20;
                  2:       stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            stretch_left--;
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      zero_code = sample_type'(OFFSET_RESET);
      window_setting = WINDOW_RESET;
      gain_q8 = GAIN_RESET;
      for (int ch = 0; ch < 3; ch++)
         square_acc[ch] = '0;
      triples_in_window = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_field_extremes();
      test_zero_window_and_gain();
      test_long_then_short_window();
      test_random_windows(600);
      test_backpressure();
      test_long_window_saturation();
      wait_idle();
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
